// ----- rtl/core/gbpp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Grid BFS path planner package
// Shared constants, codes and the controller state type of the planner.
// ----------------------------------------------------------------------------
package gbpp_pkg;

    localparam int GRID_SIDE_DEF = 8;
    localparam int MAX_RESULTS   = 64;
    localparam int CNT_W         = $clog2(MAX_RESULTS);

    localparam int COORD_W   = 3;
    localparam int HEADING_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y = 1'd1;

    localparam logic CMD_OBSTACLE = 1'b0;
    localparam logic CMD_PLAN     = 1'b1;

    localparam logic [HEADING_W-1:0] DIR_POS_X = 2'd0;
    localparam logic [HEADING_W-1:0] DIR_POS_Y = 2'd1;
    localparam logic [HEADING_W-1:0] DIR_NEG_X = 2'd2;
    localparam logic [HEADING_W-1:0] DIR_NEG_Y = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_EXPAND,
        ST_DRAIN,
        ST_WALK_RD,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/grid_bfs_path_planner_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Grid BFS path planner
// Keeps an obstacle map of a square grid and emits shortest paths found by a
// breadth-first search from the configured destination.
// ----------------------------------------------------------------------------
// After reset the block clears its cell memory one entry per cycle and takes
// no command while it does so. A plan command runs the search one neighbor
// check per cycle, the cell memory read of one check overlapping the decision
// on the one before: each cell taken from the search queue goes through one
// queue memory read, four neighbor reads and a last decision. The path
// is then walked back through the cell memory, one read and one emit step per
// node, the emit step waiting while the result channel stalls. A new command
// is taken only once the previous plan has placed its last node in the
// output register.
module grid_bfs_path_planner_top #(
    parameter int GRID_SIDE = gbpp_pkg::GRID_SIDE_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [gbpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gbpp_pkg::COORD_W-1:0]      cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_cmd,
    input  wire logic [gbpp_pkg::COORD_W-1:0]      s_pos_x,
    input  wire logic [gbpp_pkg::COORD_W-1:0]      s_pos_y,
    input  wire logic [gbpp_pkg::HEADING_W-1:0]    s_heading,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [gbpp_pkg::COORD_W-1:0]           m_node_x,
    output logic [gbpp_pkg::COORD_W-1:0]           m_node_y,
    output logic                                   m_last,
    output logic                                   m_reached
);
    import gbpp_pkg::*;

    localparam int CW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int QW    = AW + 1;
    localparam int XW    = (CW > COORD_W) ? CW : COORD_W;
    localparam logic [CW-1:0] SIDE_MAX = CW'(GRID_SIDE - 1);

    state_t state_reg, state_next;

    logic [COORD_W-1:0] dest_x_reg, dest_y_reg;
    logic [DEPTH-1:0]   visited_reg, visited_next;
    logic [QW-1:0]      head_reg, head_next;
    logic [QW-1:0]      tail_reg, tail_next;
    logic [1:0]         dir_reg, dir_next;
    logic [XW-1:0]      node_x_reg, node_x_next;
    logic [XW-1:0]      node_y_reg, node_y_next;
    logic               reached_reg, reached_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               chk_on_reg, chk_on_next;
    logic [AW-1:0]      chk_idx_reg, chk_idx_next;

    logic               m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] m_node_x_reg, m_node_x_next;
    logic [COORD_W-1:0] m_node_y_reg, m_node_y_next;
    logic               m_last_reg, m_last_next;
    logic               m_reached_reg, m_reached_next;

    logic [AW-1:0] q_mem [DEPTH];
    logic [AW:0]   c_mem [DEPTH];
    logic          q_we, q_re, c_we, c_re;
    logic [AW-1:0] q_waddr, q_wdata, q_rdata;
    logic [AW-1:0] c_waddr, c_raddr;
    logic [AW:0]   c_wdata, c_rdata;

    logic [CW-1:0]        step_x, step_y, nb_x, nb_y;
    logic [1:0]           step_dir;
    logic                 step_ok;
    logic [AW-1:0]        nb_idx, goal_idx, node_idx;
    logic                 pos_in, dest_in, search_go, walk_end, out_free, chk_take;
    logic [COORD_W-1:0]   adj_x, adj_y;

    assign pos_in   = (32'(s_pos_x) < GRID_SIDE) && (32'(s_pos_y) < GRID_SIDE);
    assign dest_in  = (32'(dest_x_reg) < GRID_SIDE) && (32'(dest_y_reg) < GRID_SIDE);
    assign goal_idx = {CW'(dest_x_reg), CW'(dest_y_reg)};
    assign node_idx = {node_x_reg[CW-1:0], node_y_reg[CW-1:0]};
    assign nb_idx   = {nb_x, nb_y};
    assign out_free = !m_valid_reg || m_ready;
    assign chk_take = chk_on_reg && !c_rdata[AW] && !visited_reg[chk_idx_reg];

    assign search_go = (head_reg < tail_reg) && !visited_reg[node_idx];
    assign walk_end  = !reached_reg || (node_idx == goal_idx)
                       || (cnt_reg == CNT_W'(MAX_RESULTS - 1));

    // A start cell whose y lies beyond the grid is reported by its cell number
    // split again into row and column.
    always_comb begin
        adj_x = s_pos_x;
        adj_y = s_pos_y;
        for (int i = 0; i < 4; i++) begin
            if (32'(adj_y) >= GRID_SIDE) begin
                adj_y = adj_y - COORD_W'(GRID_SIDE);
                adj_x = adj_x + COORD_W'(1);
            end
        end
    end

    always_comb begin
        if (state_reg == ST_IDLE) begin
            step_x   = CW'(s_pos_x);
            step_y   = CW'(s_pos_y);
            step_dir = s_heading;
        end else begin
            step_x   = q_rdata[AW-1:CW];
            step_y   = q_rdata[CW-1:0];
            step_dir = dir_reg;
        end
        nb_x    = step_x;
        nb_y    = step_y;
        step_ok = 1'b0;
        case (step_dir)
            DIR_POS_X: begin
                step_ok = (step_x != SIDE_MAX);
                nb_x    = step_x + CW'(1);
            end
            DIR_POS_Y: begin
                step_ok = (step_y != SIDE_MAX);
                nb_y    = step_y + CW'(1);
            end
            DIR_NEG_X: begin
                step_ok = (step_x != '0);
                nb_x    = step_x - CW'(1);
            end
            DIR_NEG_Y: begin
                step_ok = (step_y != '0);
                nb_y    = step_y - CW'(1);
            end
            default: begin
                step_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (tail_reg[AW-1:0] == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_cmd == CMD_PLAN) begin
                    state_next = (pos_in && dest_in) ? ST_POP : ST_WALK_RD;
                end
            end
            ST_POP: begin
                state_next = search_go ? ST_EXPAND : ST_WALK_RD;
            end
            ST_EXPAND: begin
                if (dir_reg == DIR_NEG_Y) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_POP;
            end
            ST_WALK_RD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = walk_end ? ST_IDLE : ST_WALK_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        visited_next   = visited_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        dir_next       = dir_reg;
        node_x_next    = node_x_reg;
        node_y_next    = node_y_reg;
        reached_next   = reached_reg;
        cnt_next       = cnt_reg;
        chk_on_next    = chk_on_reg;
        chk_idx_next   = chk_idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_node_x_next  = m_node_x_reg;
        m_node_y_next  = m_node_y_reg;
        m_last_next    = m_last_reg;
        m_reached_next = m_reached_reg;
        q_we    = 1'b0;
        q_re    = 1'b0;
        q_waddr = tail_reg[AW-1:0];
        q_wdata = chk_idx_reg;
        c_we    = 1'b0;
        c_re    = 1'b0;
        c_waddr = chk_idx_reg;
        c_wdata = {1'b0, q_rdata};
        c_raddr = node_idx;
        case (state_reg)
            ST_CLEAR: begin
                c_we      = 1'b1;
                c_waddr   = tail_reg[AW-1:0];
                c_wdata   = '0;
                tail_next = tail_reg + QW'(1);
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_OBSTACLE) begin
                        if (pos_in && step_ok) begin
                            c_we    = 1'b1;
                            c_waddr = nb_idx;
                            c_wdata = {1'b1, {AW{1'b0}}};
                        end
                    end else begin
                        node_x_next = XW'(adj_x);
                        node_y_next = XW'(adj_y);
                        cnt_next    = '0;
                        if (pos_in && dest_in) begin
                            visited_next           = '0;
                            visited_next[goal_idx] = 1'b1;
                            q_we      = 1'b1;
                            q_waddr   = '0;
                            q_wdata   = goal_idx;
                            head_next = '0;
                            tail_next = QW'(1);
                        end else begin
                            reached_next = 1'b0;
                        end
                    end
                end
            end
            ST_POP: begin
                if (search_go) begin
                    q_re        = 1'b1;
                    head_next   = head_reg + QW'(1);
                    dir_next    = DIR_POS_X;
                    chk_on_next = 1'b0;
                end else begin
                    reached_next = visited_reg[node_idx];
                end
            end
            ST_EXPAND: begin
                if (chk_take) begin
                    visited_next[chk_idx_reg] = 1'b1;
                    c_we      = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + QW'(1);
                end
                c_re         = 1'b1;
                c_raddr      = nb_idx;
                chk_on_next  = step_ok;
                chk_idx_next = nb_idx;
                dir_next     = dir_reg + 2'd1;
            end
            ST_DRAIN: begin
                if (chk_take) begin
                    visited_next[chk_idx_reg] = 1'b1;
                    c_we      = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + QW'(1);
                end
                chk_on_next = 1'b0;
            end
            ST_WALK_RD: begin
                c_re = 1'b1;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_node_x_next  = node_x_reg[COORD_W-1:0];
                    m_node_y_next  = node_y_reg[COORD_W-1:0];
                    m_last_next    = walk_end;
                    m_reached_next = reached_reg;
                    if (!walk_end) begin
                        node_x_next = XW'(c_rdata[AW-1:CW]);
                        node_y_next = XW'(c_rdata[CW-1:0]);
                        cnt_next    = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            q_rdata <= q_mem[head_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (c_we) begin
            c_mem[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            c_rdata <= c_mem[c_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            dest_x_reg  <= '0;
            dest_y_reg  <= '0;
            visited_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DEST_X: dest_x_reg <= cfg_wdata;
                    CFG_DEST_Y: dest_y_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        dir_reg       <= dir_next;
        node_x_reg    <= node_x_next;
        node_y_reg    <= node_y_next;
        reached_reg   <= reached_next;
        cnt_reg       <= cnt_next;
        chk_on_reg    <= chk_on_next;
        chk_idx_reg   <= chk_idx_next;
        m_node_x_reg  <= m_node_x_next;
        m_node_y_reg  <= m_node_y_next;
        m_last_reg    <= m_last_next;
        m_reached_reg <= m_reached_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_node_x  = m_node_x_reg;
    assign m_node_y  = m_node_y_reg;
    assign m_last    = m_last_reg;
    assign m_reached = m_reached_reg;

endmodule
`default_nettype wire
